>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, disabled while reset is asserted
`define GSB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check that also holds during reset
`define GSB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GSB_ASSERT(lbl, clk, rst_n, prop, msg)
`define GSB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> hw/rtl/gsb_pkg.sv
// types and constants of the growable symbol buffer
package gsb_pkg;

  localparam int FW  = 13;   // width of the position and count fields
  localparam int PAW = 4;    // apb address width
  localparam int PERCENT = 100;

  localparam logic [3:0] ACT_ADD     = 4'd0;
  localparam logic [3:0] ACT_GET     = 4'd1;
  localparam logic [3:0] ACT_MARK    = 4'd2;
  localparam logic [3:0] ACT_RETRACT = 4'd3;
  localparam logic [3:0] ACT_RESET   = 4'd4;
  localparam logic [3:0] ACT_REWIND  = 4'd5;
  localparam logic [3:0] ACT_CLEAR   = 4'd6;
  localparam logic [3:0] ACT_COMPACT = 4'd7;
  localparam logic [3:0] ACT_READ_AT = 4'd8;

  localparam logic [1:0] GROW_ADD  = 2'd1;
  localparam logic [1:0] GROW_MULT = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_FACTOR = 2'd1;
  localparam logic [1:0] REG_START  = 2'd2;

  typedef struct packed {
    logic [3:0]    action;
    logic [7:0]    symbol;
    logic [FW-1:0] position;
  } gsb_in_t;

  typedef struct packed {
    logic          ok;
    logic [7:0]    data;
    logic [FW-1:0] fill_count;
    logic [FW-1:0] cur_capacity;
    logic [FW-1:0] read_index;
    logic [FW-1:0] mark_index;
    logic          end_flag;
    logic          is_full;
    logic          is_empty;
    logic          grew;
  } gsb_out_t;

  typedef struct packed {
    logic [1:0]    mode;
    logic [7:0]    factor;
    logic          cap_load;
    logic [FW-1:0] cap_value;
  } gsb_cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic exec;
  } gsb_cmd_t;

  typedef struct packed {
    logic grow_mul;
  } gsb_status_t;

endpackage

>>> hw/rtl/gsb_ram.sv
// generic single-port-write ram with registered read
module gsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/gsb_regs.sv
// apb configuration registers
module gsb_regs
  import gsb_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output gsb_cfg_t       cfg
);

  logic [1:0]    mode_r;
  logic [7:0]    factor_r;
  logic [FW-1:0] start_r;
  logic          wr;
  logic [1:0]    idx;

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      factor_r <= '0;
      start_r  <= FW'(1);
    end else if (wr) begin
      unique case (idx)
        REG_MODE:   mode_r   <= pwdata[1:0];
        REG_FACTOR: factor_r <= pwdata[7:0];
        REG_START:  start_r  <= pwdata[FW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = {30'd0, mode_r};
      REG_FACTOR: prdata = {24'd0, factor_r};
      REG_START:  prdata = {{(32-FW){1'b0}}, start_r};
      default:    prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign cfg.mode      = mode_r;
  assign cfg.factor    = factor_r;
  assign cfg.cap_load  = wr && (idx == REG_START);
  assign cfg.cap_value = pwdata[FW-1:0];

endmodule

>>> hw/rtl/gsb_ctrl.sv
// controller state machine of the symbol buffer
`include "assert_macros.svh"
module gsb_ctrl
  import gsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  gsb_status_t status,
  output logic        busy,
  output gsb_cmd_t    cmd,
  output logic        out_valid
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          // multiplicative growth needs the percent product first
          state_nxt = status.grow_mul ? S_MUL : S_EXEC;
        end
      end
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  assign cmd.load  = accept;
  assign cmd.mul   = (state_r == S_MUL);
  assign cmd.div   = (state_r == S_DIV);
  assign cmd.exec  = (state_r == S_EXEC);
  assign out_valid = out_valid_r;

  `GSB_ASSERT(a_strobe_single, clk, rst_n, out_valid_r |=> !out_valid_r, "result strobe longer than one cycle")
  `GSB_ASSERT(a_exec_strobe, clk, rst_n, (state_r == S_EXEC) |=> out_valid_r, "executed request without result")
  `GSB_ASSERT(a_mul_div_exec, clk, rst_n, (state_r == S_MUL) |=> ((state_r == S_DIV) ##1 (state_r == S_EXEC)), "growth sequence broken")

endmodule

>>> hw/rtl/gsb_dp.sv
// datapath: pointers, capacity growth, symbol store and result register
`include "assert_macros.svh"
module gsb_dp
  import gsb_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  gsb_cmd_t    cmd,
  input  gsb_cfg_t    cfg,
  input  gsb_in_t     in_req,
  output gsb_status_t status,
  output gsb_out_t    out_res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int XW = ((CW > FW) ? CW : FW) + 2;
  localparam int PW = CW + 8;
  // exact reciprocal of the percent divisor for PW-bit dividends
  localparam int SH = PW + 7;
  localparam int RW = PW + 1;
  localparam int QW = PW - 6;
  localparam int MW = PW + RW;
  localparam longint unsigned RECIP_L = ((64'd1 << SH) + 64'(PERCENT - 1)) / 64'(PERCENT);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] mark_r, mark_nxt;
  logic [CW-1:0] cap_r, cap_nxt;
  logic          end_r, end_nxt;
  gsb_in_t       req_r;
  logic [PW-1:0] prod_r;
  logic [QW-1:0] quot_r;
  gsb_out_t      out_r;
  gsb_out_t      res;

  logic [MW-1:0] recip_prod;
  logic [XW-1:0] cnt_x, cap_x, rp_x, pos_x, dep_x, start_x, nc_x, nc_c, rd_x;
  logic          full, grow_ok, add_go, we;
  logic [7:0]    rdata;

  assign dep_x   = XW'(DEPTH);
  assign cnt_x   = XW'(count_r);
  assign cap_x   = XW'(cap_r);
  assign rp_x    = XW'(rp_r);
  assign pos_x   = XW'(req_r.position);
  assign start_x = XW'(cfg.cap_value);
  assign full    = (cnt_x >= cap_x);

  assign status.grow_mul = (in_req.action == ACT_ADD) && full && (cfg.mode == GROW_MULT);

  // read port is addressed from the incoming request
  assign rd_x = (in_req.action == ACT_GET) ? rp_x : XW'(in_req.position);

  assign recip_prod = MW'(prod_r) * MW'(RECIP);

  always_comb begin
    if (cfg.mode == GROW_MULT) begin
      nc_x = (quot_r == '0) ? dep_x : cap_x + XW'(quot_r);
    end else begin
      nc_x = cap_x + XW'(cfg.factor);
    end
    nc_c    = (nc_x > dep_x) ? dep_x : nc_x;
    grow_ok = (cfg.factor != 8'd0) &&
              ((cfg.mode == GROW_ADD) || (cfg.mode == GROW_MULT)) &&
              (cap_x < dep_x) && (nc_c > cnt_x);
  end

  always_comb begin
    count_nxt = count_r;
    rp_nxt    = rp_r;
    mark_nxt  = mark_r;
    cap_nxt   = cap_r;
    end_nxt   = end_r;
    add_go    = 1'b0;
    we        = 1'b0;
    res       = '0;
    if (cfg.cap_load) begin
      cap_nxt = (start_x > dep_x) ? CW'(DEPTH) : CW'(start_x);
    end
    if (cmd.exec) begin
      case (req_r.action)
        ACT_ADD: begin
          if (full) begin
            if (grow_ok) begin
              res.grew = (nc_c != cap_x);
              cap_nxt  = CW'(nc_c);
              add_go   = 1'b1;
            end
          end else begin
            add_go = 1'b1;
          end
          if (add_go && (cnt_x < dep_x)) begin
            we        = 1'b1;
            count_nxt = count_r + CW'(1);
            res.ok    = 1'b1;
          end
        end
        ACT_GET: begin
          if ((rp_x >= cnt_x) || (rp_x >= dep_x)) begin
            end_nxt = 1'b1;
          end else begin
            end_nxt  = 1'b0;
            res.data = rdata;
            rp_nxt   = rp_r + CW'(1);
            res.ok   = 1'b1;
          end
        end
        ACT_MARK: begin
          if (pos_x <= cnt_x) begin
            mark_nxt = CW'(pos_x);
            res.ok   = 1'b1;
          end
        end
        ACT_RETRACT: begin
          if (rp_r != '0) begin
            rp_nxt = rp_r - CW'(1);
            res.ok = 1'b1;
          end
        end
        ACT_RESET: begin
          rp_nxt = mark_r;
          res.ok = 1'b1;
        end
        ACT_REWIND: begin
          rp_nxt   = '0;
          mark_nxt = '0;
          res.ok   = 1'b1;
        end
        ACT_CLEAR: begin
          count_nxt = '0;
          rp_nxt    = '0;
          mark_nxt  = '0;
          res.ok    = 1'b1;
        end
        ACT_COMPACT: begin
          if (cnt_x < dep_x) begin
            cap_nxt   = count_r + CW'(1);
            we        = 1'b1;
            count_nxt = count_r + CW'(1);
            res.ok    = 1'b1;
          end
        end
        ACT_READ_AT: begin
          if ((pos_x < cnt_x) && (pos_x < dep_x)) begin
            res.data = rdata;
            res.ok   = 1'b1;
          end else if (pos_x == cnt_x) begin
            res.ok = 1'b1;
          end
        end
        default: ;
      endcase
    end
    res.fill_count   = FW'(count_nxt);
    res.cur_capacity = FW'(cap_nxt);
    res.read_index   = FW'(rp_nxt);
    res.mark_index   = FW'(mark_nxt);
    res.end_flag     = end_nxt;
    res.is_full      = (XW'(count_nxt) >= XW'(cap_nxt));
    res.is_empty     = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rp_r    <= '0;
      mark_r  <= '0;
      cap_r   <= CW'(1);
      end_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      rp_r    <= rp_nxt;
      mark_r  <= mark_nxt;
      cap_r   <= cap_nxt;
      end_r   <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (cmd.mul) begin
      prod_r <= PW'(CW'(DEPTH) - cap_r) * PW'(cfg.factor);
    end
    if (cmd.div) begin
      quot_r <= recip_prod[SH+QW-1:SH];
    end
    if (cmd.exec) begin
      out_r <= res;
    end
  end

  gsb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[AW-1:0]),
    .wdata (req_r.symbol),
    .raddr (rd_x[AW-1:0]),
    .rdata (rdata)
  );

  assign out_res = out_r;

  `GSB_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH), "fill count above depth")
  `GSB_ASSERT(a_read_in_fill, clk, rst_n, rp_r <= count_r, "read position past fill count")
  `GSB_ASSERT(a_mark_in_fill, clk, rst_n, mark_r <= count_r, "mark position past fill count")

endmodule

>>> hw/rtl/growable_symbol_buffer_unit.sv
// top level of the growable symbol buffer
// A request is taken when start is high and busy is low; its result appears on out_res
// for one cycle with out_valid high, after the execute state and the output register.
// Busy drops after that execute state, so a new request can be taken in the same cycle
// as the result appears. An add that must grow a full buffer in multiplicative mode
// first passes a percent multiply state and a reciprocal multiply state. The execute
// cycle is set by the registered read port of the symbol store. The result side
// cannot stall, so results must be taken as they come. The symbol store needs no
// clearing after reset: only written entries are ever read. Configuration goes through
// the apb port; the user must do so while no request is in flight, as the block does not check.
module growable_symbol_buffer_unit
  import gsb_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  gsb_in_t        in_req,
  output logic           out_valid,
  output gsb_out_t       out_res,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  gsb_cfg_t    cfg;
  gsb_cmd_t    cmd;
  gsb_status_t status;

  gsb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  gsb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .cfg     (cfg),
    .in_req  (in_req),
    .status  (status),
    .out_res (out_res)
  );

endmodule
